// ===== rtl/core/typed_stack_calculator_defines.svh =====
// ----------------------------------------------------------------------------
// Typed stack calculator assertion macros
// Shared assertion wrappers for the calculator RTL.
// ----------------------------------------------------------------------------
`ifndef TYPED_STACK_CALCULATOR_DEFINES_SVH
`define TYPED_STACK_CALCULATOR_DEFINES_SVH

// Assert that a condition implies a consequence on the same edge.
`define TSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition implies a consequence on the next edge.
`define TSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Typed stack calculator package
// Opcodes, status codes, widths and the cell command type.
// ----------------------------------------------------------------------------
package tsc_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = DATA_WIDTH + 1;

    typedef logic [ENTRY_W-1:0] t_entry;

    localparam logic [4:0] OP_PUSHINT = 5'd0;
    localparam logic [4:0] OP_TRUE    = 5'd1;
    localparam logic [4:0] OP_FALSE   = 5'd2;
    localparam logic [4:0] OP_NOT     = 5'd3;
    localparam logic [4:0] OP_PRINT   = 5'd4;
    localparam logic [4:0] OP_CLEAR   = 5'd5;
    localparam logic [4:0] OP_DROP    = 5'd6;
    localparam logic [4:0] OP_DUP     = 5'd7;
    localparam logic [4:0] OP_SWAP    = 5'd8;
    localparam logic [4:0] OP_ADD     = 5'd9;
    localparam logic [4:0] OP_SUB     = 5'd10;
    localparam logic [4:0] OP_MUL     = 5'd11;
    localparam logic [4:0] OP_DIV     = 5'd12;
    localparam logic [4:0] OP_MOD     = 5'd13;
    localparam logic [4:0] OP_EQ      = 5'd14;
    localparam logic [4:0] OP_LT      = 5'd15;
    localparam logic [4:0] OP_GT      = 5'd16;
    localparam logic [4:0] OP_LE      = 5'd17;
    localparam logic [4:0] OP_GE      = 5'd18;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTBOOL  = 3'd2;
    localparam logic [2:0] ST_NOTINT   = 3'd3;
    localparam logic [2:0] ST_DIVZERO  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_UNIMPL   = 3'd6;

    // Whole-row command: every cell takes the same one.
    typedef enum logic [2:0] {
        C_HOLD,   // keep entry
        C_PUSH,   // shift down, top gets new value
        C_POP,    // shift up
        C_POP2,   // two leave, one result lands on top: shift up by one
        C_TOP,    // replace top only
        C_SWAP,   // exchange top and second
        C_DROP2   // shift up by two, nothing pushed
    } t_cmd;

    typedef struct packed {
        t_cmd   cmd;
        t_entry data;
    } t_row_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;
endpackage

// ===== rtl/core/tsc_cell.sv =====
// ----------------------------------------------------------------------------
// Stack cell
// One stack slot; cell 0 is the top. Shifts with its neighbours per command.
// ----------------------------------------------------------------------------
module tsc_cell
    import tsc_pkg::*;
(
    input  logic     i_clk,
    input  t_row_ctl i_ctl,
    input  t_entry   i_above,    // cell k-1 (or pushed data at top)
    input  t_entry   i_below,    // cell k+1
    input  t_entry   i_below2,   // cell k+2
    input  logic     i_is_top,
    input  logic     i_is_second,
    output t_entry   o_entry
);
    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.cmd)
            C_HOLD: n_entry = r_entry;
            C_PUSH: n_entry = i_is_top ? i_ctl.data : i_above;
            C_POP:  n_entry = i_below;
            // Two operands leave, result lands on the new top.
            C_POP2: n_entry = i_is_top ? i_ctl.data : i_below;
            C_TOP:  n_entry = i_is_top ? i_ctl.data : r_entry;
            C_SWAP: n_entry = i_is_top ? i_below : (i_is_second ? i_above : r_entry);
            C_DROP2: n_entry = i_below2;
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

// ===== rtl/core/tsc_divider.sv =====
// ----------------------------------------------------------------------------
// Stack calculator divider
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tsc_divider
    import tsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quot,
    output logic [DATA_WIDTH-1:0] o_rem
);
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_q, n_q;
    logic [DATA_WIDTH:0]   r_r, n_r;
    logic [DATA_WIDTH-1:0] r_d;
    logic                  r_qneg, r_rneg;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy, r_done;
    logic [DATA_WIDTH:0]   trial;

    always_comb begin
        trial = {r_r[DATA_WIDTH-1:0], r_q[DATA_WIDTH-1]} - {1'b0, r_d};
        if (!trial[DATA_WIDTH]) begin
            n_r = trial;
            n_q = {r_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
            n_r = {r_r[DATA_WIDTH-1:0], r_q[DATA_WIDTH-1]};
            n_q = {r_q[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num[DATA_WIDTH-1] ? (~i_num + 1'b1) : i_num;
            r_d    <= i_den[DATA_WIDTH-1] ? (~i_den + 1'b1) : i_den;
            r_r    <= '0;
            r_qneg <= i_num[DATA_WIDTH-1] ^ i_den[DATA_WIDTH-1];
            r_rneg <= i_num[DATA_WIDTH-1];
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_rneg ? (~r_r[DATA_WIDTH-1:0] + 1'b1) : r_r[DATA_WIDTH-1:0];

    `include "typed_stack_calculator_defines.svh"
    `TSC_ASSERT_NXT(a_div_busy, i_clk, i_rst_n, i_start, r_busy)
    `TSC_ASSERT_IMP(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `TSC_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0)
endmodule

// ===== rtl/core/typed_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// Typed stack calculator
// Typed reverse-Polish stack machine over a row of shifting cells.
// ----------------------------------------------------------------------------
// Each transaction takes one opcode and returns one result. Most opcodes
// finish in the S_DONE state; div and mod wait in S_DIV for the
// one-bit-per-cycle divider. The stack is a row of 64 cells, cell 0 the
// top, all shifting together, so no clearing pass is needed after reset. A
// new opcode is taken once the previous result has left the output register.
// ----------------------------------------------------------------------------
module typed_stack_calculator
    import tsc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [4:0]                   i_mode,
    input  logic signed [31:0]           i_operand,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic                         o_shown_valid,
    output logic                         o_shown_is_bool,
    output logic signed [31:0]           o_shown_value,
    output logic [6:0]                   o_depth
);
    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_row_ctl          ctl;
    t_entry            cells [STACK_DEPTH];
    logic [4:0]        r_mode;
    logic [DATA_WIDTH-1:0] r_oper;
    logic [2:0]        r_status, n_status;
    logic              r_sv, n_sv, r_sb, n_sb;
    logic [31:0]       r_sval, n_sval;
    logic              div_start, div_done;
    logic [DATA_WIDTH-1:0] quot, remd;
    logic              accept;

    t_entry top, sec;
    logic   top_b, sec_b;
    logic [DATA_WIDTH-1:0] a, b;
    logic   lt;

    assign top   = cells[0];
    assign sec   = cells[1];
    assign top_b = top[DATA_WIDTH];
    assign sec_b = sec[DATA_WIDTH];
    assign a     = sec[DATA_WIDTH-1:0];
    assign b     = top[DATA_WIDTH-1:0];
    assign lt    = $signed(a) < $signed(b);

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || o_valid;

    genvar k;
    generate
        for (k = 0; k < STACK_DEPTH; k++) begin : g_cell
            t_entry above, below, below2;
            if (k == 0) begin : g_t
                assign above = ctl.data;
            end else begin : g_a
                assign above = cells[k-1];
            end
            if (k + 1 < STACK_DEPTH) begin : g_b
                assign below = cells[k+1];
            end else begin : g_bz
                assign below = '0;
            end
            if (k + 2 < STACK_DEPTH) begin : g_b2
                assign below2 = cells[k+2];
            end else begin : g_b2z
                assign below2 = '0;
            end
            tsc_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_above    (above),
                .i_below    (below),
                .i_below2   (below2),
                .i_is_top   (k == 0),
                .i_is_second(k == 1),
                .o_entry    (cells[k])
            );
        end
    endgenerate

    tsc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (a),
        .i_den  (b),
        .o_done (div_done),
        .o_quot (quot),
        .o_rem  (remd)
    );

    function automatic t_entry mk_bool(input logic v);
        mk_bool = {1'b1, {(DATA_WIDTH-1){1'b0}}, v};
    endfunction

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_status  = r_status;
        n_sv      = r_sv;
        n_sb      = r_sb;
        n_sval    = r_sval;
        ctl       = '{C_HOLD, '0};
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
                n_status = ST_OK;
                n_sv = 1'b0;
                n_sb = 1'b0;
                n_sval = '0;
                priority case (r_mode)
                    OP_PUSHINT, OP_TRUE, OP_FALSE: begin
                        if (r_fill == FILL_W'(STACK_DEPTH)) n_status = ST_OVERFLOW;
                        else begin
                            ctl = '{C_PUSH, (r_mode == OP_PUSHINT) ? {1'b0, r_oper}
                                   : mk_bool(r_mode == OP_TRUE)};
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    OP_NOT: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else if (!top_b) n_status = ST_NOTBOOL;
                        else ctl = '{C_TOP, mk_bool(!top[0])};
                    end
                    OP_PRINT: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else begin
                            n_sv = 1'b1;
                            n_sb = top_b;
                            n_sval = top_b ? {31'b0, top[0]} : 32'(signed'(b));
                        end
                    end
                    OP_CLEAR: n_fill = '0;
                    OP_DROP: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else begin
                            ctl = '{C_POP, '0};
                            n_fill = r_fill - 1'b1;
                        end
                    end
                    OP_DUP: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else if (r_fill == FILL_W'(STACK_DEPTH)) n_status = ST_OVERFLOW;
                        else begin
                            ctl = '{C_PUSH, top};
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    OP_SWAP: begin
                        if (r_fill < FILL_W'(2)) begin
                            n_status = ST_EMPTY;
                            n_fill = '0;
                        end else ctl = '{C_SWAP, '0};
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else if (top_b) begin
                            n_status = ST_NOTINT;
                            ctl = '{C_POP, '0};
                            n_fill = r_fill - 1'b1;
                        end else if (r_fill == FILL_W'(1)) begin
                            n_status = ST_EMPTY;
                            ctl = '{C_POP, '0};
                            n_fill = '0;
                        end else if (sec_b) begin
                            n_status = ST_NOTINT;
                            ctl = '{C_DROP2, '0};
                            n_fill = r_fill - 2'd2;
                        end else if (r_mode == OP_ADD) begin
                            ctl = '{C_POP2, {1'b0, a + b}};
                            n_fill = r_fill - 1'b1;
                        end else if (r_mode == OP_SUB) begin
                            ctl = '{C_POP2, {1'b0, a - b}};
                            n_fill = r_fill - 1'b1;
                        end else if (r_mode == OP_MUL) begin
                            ctl = '{C_POP2, {1'b0, DATA_WIDTH'(a * b)}};
                            n_fill = r_fill - 1'b1;
                        end else if (b == '0) begin
                            n_status = ST_DIVZERO;
                            ctl = '{C_DROP2, '0};
                            n_fill = r_fill - 2'd2;
                        end else begin
                            div_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                    OP_EQ: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else if (r_fill == FILL_W'(1)) begin
                            n_status = ST_EMPTY;
                            ctl = '{C_POP, '0};
                            n_fill = '0;
                        end else begin
                            ctl = '{C_POP2, mk_bool(top == sec)};
                            n_fill = r_fill - 1'b1;
                        end
                    end
                    OP_LT, OP_GT, OP_LE, OP_GE: begin
                        if (r_fill == '0) n_status = ST_EMPTY;
                        else if (r_fill == FILL_W'(1)) begin
                            n_status = ST_EMPTY;
                            ctl = '{C_POP, '0};
                            n_fill = '0;
                        end else if (top_b || sec_b) begin
                            n_status = ST_NOTINT;
                            ctl = '{C_POP, '0};
                            n_fill = r_fill - 1'b1;
                        end else begin
                            unique case (r_mode)
                                OP_LT: ctl = '{C_POP2, mk_bool(lt)};
                                OP_GT: ctl = '{C_POP2, mk_bool(!lt && a != b)};
                                OP_LE: ctl = '{C_POP2, mk_bool(lt || a == b)};
                                default: ctl = '{C_POP2, mk_bool(!lt)};
                            endcase
                            n_fill = r_fill - 1'b1;
                        end
                    end
                    default: n_status = ST_UNIMPL;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                    n_status = ST_OK;
                    n_sv = 1'b0;
                    n_sb = 1'b0;
                    n_sval = '0;
                    ctl = '{C_POP2, {1'b0, (r_mode == OP_DIV) ? quot : remd}};
                    n_fill = r_fill - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic r_ov;
    logic fin;
    assign fin = (r_state == S_DONE && n_state == S_IDLE) ||
                 (r_state == S_DIV && div_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (fin) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_oper <= DATA_WIDTH'(i_operand);
        end
        if (fin) begin
            r_status <= n_status;
            r_sv     <= n_sv;
            r_sb     <= n_sb;
            r_sval   <= n_sval;
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_status;
    assign o_shown_valid   = r_sv;
    assign o_shown_is_bool = r_sb;
    assign o_shown_value   = r_sval;
    assign o_depth         = 7'(r_fill);

    `include "typed_stack_calculator_defines.svh"
    `TSC_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(STACK_DEPTH))
    `TSC_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `TSC_ASSERT_NXT(a_fin_valid, i_clk, i_rst_n, fin, o_valid)
endmodule

// ===== tb/sv/tb_typed_stack_calculator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Typed stack calculator testbench
// Drives opcode transactions with random idling on both channels, predicts
// every result with a behavioural stack model and compares each field.
// ----------------------------------------------------------------------------

class calc_scoreboard;
    typedef struct packed {
        logic [2:0]  status;
        logic        shown_valid;
        logic        shown_is_bool;
        logic [31:0] shown_value;
        logic [6:0]  depth;
    } t_outcome;

    logic [tsc_pkg::ENTRY_W-1:0] stack_mem [tsc_pkg::STACK_DEPTH];
    int unsigned                 level;
    t_outcome                    pending_q [$];
    int                          fail_count;

    function new();
        level      = 0;
        fail_count = 0;
    endfunction

    function automatic logic [32:0] bool_entry(bit b);
        return {1'b1, 31'd0, b};
    endfunction

    function automatic logic [32:0] pop();
        level--;
        return stack_mem[level];
    endfunction

    function automatic void push(logic [32:0] e);
        stack_mem[level] = e;
        level++;
    endfunction

    // Apply one opcode to the model stack and queue the expected result.
    function automatic void note_command(logic [4:0] mode, logic [31:0] operand);
        t_outcome   res;
        logic [32:0] a, b;
        logic signed [31:0] x, y;
        res = '0;
        res.status = tsc_pkg::ST_OK;
        case (mode)
            tsc_pkg::OP_PUSHINT, tsc_pkg::OP_TRUE, tsc_pkg::OP_FALSE: begin
                if (level >= tsc_pkg::STACK_DEPTH) res.status = tsc_pkg::ST_OVERFLOW;
                else if (mode == tsc_pkg::OP_PUSHINT) push({1'b0, operand});
                else push(bool_entry(mode == tsc_pkg::OP_TRUE));
            end
            tsc_pkg::OP_NOT: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else if (!stack_mem[level-1][32]) res.status = tsc_pkg::ST_NOTBOOL;
                else stack_mem[level-1] = bool_entry(!stack_mem[level-1][0]);
            end
            tsc_pkg::OP_PRINT: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else begin
                    a = stack_mem[level-1];
                    res.shown_valid   = 1'b1;
                    res.shown_is_bool = a[32];
                    res.shown_value   = a[32] ? {31'd0, a[0]} : a[31:0];
                end
            end
            tsc_pkg::OP_CLEAR: level = 0;
            tsc_pkg::OP_DROP: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else a = pop();
            end
            tsc_pkg::OP_DUP: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else if (level >= tsc_pkg::STACK_DEPTH) res.status = tsc_pkg::ST_OVERFLOW;
                else push(stack_mem[level-1]);
            end
            tsc_pkg::OP_SWAP: begin
                if (level < 2) begin
                    res.status = tsc_pkg::ST_EMPTY;
                    level = 0;
                end else begin
                    a = stack_mem[level-1];
                    stack_mem[level-1] = stack_mem[level-2];
                    stack_mem[level-2] = a;
                end
            end
            tsc_pkg::OP_ADD, tsc_pkg::OP_SUB, tsc_pkg::OP_MUL,
            tsc_pkg::OP_DIV, tsc_pkg::OP_MOD: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else begin
                    b = pop();
                    if (b[32]) res.status = tsc_pkg::ST_NOTINT;
                    else if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                    else begin
                        a = pop();
                        x = a[31:0];
                        y = b[31:0];
                        if (a[32]) res.status = tsc_pkg::ST_NOTINT;
                        else if (mode == tsc_pkg::OP_ADD) push({1'b0, x + y});
                        else if (mode == tsc_pkg::OP_SUB) push({1'b0, x - y});
                        else if (mode == tsc_pkg::OP_MUL) push({1'b0, x * y});
                        else if (y == 0) res.status = tsc_pkg::ST_DIVZERO;
                        // most negative over minus one wraps to itself, mod 0
                        else if (y == -1)
                            push({1'b0, (mode == tsc_pkg::OP_DIV) ? -x : 32'sd0});
                        else push({1'b0, (mode == tsc_pkg::OP_DIV) ? x / y : x % y});
                    end
                end
            end
            tsc_pkg::OP_EQ: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else begin
                    b = pop();
                    if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                    else begin
                        a = pop();
                        push(bool_entry(a == b));
                    end
                end
            end
            tsc_pkg::OP_LT, tsc_pkg::OP_GT, tsc_pkg::OP_LE, tsc_pkg::OP_GE: begin
                if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                else begin
                    b = pop();
                    if (level == 0) res.status = tsc_pkg::ST_EMPTY;
                    else if (b[32] || stack_mem[level-1][32]) res.status = tsc_pkg::ST_NOTINT;
                    else begin
                        a = pop();
                        x = a[31:0];
                        y = b[31:0];
                        case (mode)
                            tsc_pkg::OP_LT: push(bool_entry(x < y));
                            tsc_pkg::OP_GT: push(bool_entry(x > y));
                            tsc_pkg::OP_LE: push(bool_entry(x <= y));
                            default:        push(bool_entry(x >= y));
                        endcase
                    end
                end
            end
            default: res.status = tsc_pkg::ST_UNIMPL;
        endcase
        res.depth = level[6:0];
        pending_q.push_back(res);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic check_result(t_outcome got);
        t_outcome want;
        if (pending_q.size() == 0) begin
            report("unexpected transaction", 0, 0);
            return;
        end
        want = pending_q.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.shown_valid !== want.shown_valid)
            report("shown_valid", got.shown_valid, want.shown_valid);
        if (got.shown_is_bool !== want.shown_is_bool)
            report("shown_is_bool", got.shown_is_bool, want.shown_is_bool);
        if (got.shown_value !== want.shown_value)
            report("shown_value", got.shown_value, want.shown_value);
        if (got.depth !== want.depth) report("depth", got.depth, want.depth);
    endtask
endclass

module tb_typed_stack_calculator;
    import tsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [4:0]         i_mode;
    logic signed [31:0] i_operand;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic               o_shown_valid;
    logic               o_shown_is_bool;
    logic signed [31:0] o_shown_value;
    logic [6:0]         o_depth;

    calc_scoreboard calc_sb;
    bit             quiet_phase;
    int             idle_cycles;

    typed_stack_calculator DUT (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        calc_sb   = new();
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_mode    = '0;
        i_operand = '0;
        i_stall   = 1'b0;
    end

    // Result side: check on every accepted transaction, stall in bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            calc_sb.check_result({o_status, o_shown_valid, o_shown_is_bool,
                                  o_shown_value, o_depth});
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        while (1) begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // Watchdog: count cycles with no accepted transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_command(logic [4:0] mode, logic [31:0] operand);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 19);
            repeat (n) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_operand <= operand;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        calc_sb.note_command(mode, operand);
        i_valid <= 1'b0;
        // The block stalls at least this cycle after taking a transaction.
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (calc_sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'd0;
            4:       return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return OP_PUSHINT;
        if (r < 38) return $urandom_range(0, 1) ? OP_TRUE : OP_FALSE;
        if (r < 95) return 5'($urandom_range(OP_NOT, OP_GE));
        return 5'($urandom_range(19, 31));
    endfunction

    initial begin
        int k;
        quiet_phase = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack cases, extremes, wraps, zero divisor, types.
        send_command(OP_PRINT, 0);
        send_command(OP_NOT, 0);
        send_command(OP_ADD, 0);
        send_command(OP_PUSHINT, 32'h8000_0000);
        send_command(OP_PUSHINT, 32'hffff_ffff);
        send_command(OP_DIV, 0);
        send_command(OP_PUSHINT, 32'h8000_0000);
        send_command(OP_PUSHINT, 32'hffff_ffff);
        send_command(OP_MOD, 0);
        send_command(OP_PUSHINT, 32'h7fff_ffff);
        send_command(OP_ADD, 0);
        send_command(OP_PRINT, 0);
        send_command(OP_PUSHINT, 0);
        send_command(OP_DIV, 0);
        send_command(OP_TRUE, 0);
        send_command(OP_NOT, 0);
        send_command(OP_PRINT, 0);
        send_command(OP_PUSHINT, 5);
        send_command(OP_LT, 0);
        send_command(OP_EQ, 0);
        send_command(OP_FALSE, 0);
        send_command(OP_SWAP, 0);
        send_command(OP_MUL, 0);
        send_command(5'd31, 0);
        send_command(OP_CLEAR, 0);

        // Fill to overflow, then drain.
        for (k = 0; k < STACK_DEPTH; k++) send_command(OP_PUSHINT, $urandom);
        send_command(OP_PUSHINT, 1);
        send_command(OP_TRUE, 0);
        send_command(OP_DUP, 0);
        send_command(OP_CLEAR, 0);

        // Hold the sender until every result is back.
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - 60) quiet_phase = 1'b1;
            // Keep the stack shallow most of the time so operations find operands.
            if (calc_sb.level > 12 && $urandom_range(0, 3) == 0)
                send_command(OP_DROP, 0);
            else
                send_command(pick_mode(), pick_value());
        end
        send_command(OP_CLEAR, 0);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (calc_sb.fail_count == 0 && calc_sb.pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
